/* hw/rtl/life_generation_stencil_macros.svh */
// assertion macros used by the checker file lgs_checker.sv
`ifndef LIFE_GENERATION_STENCIL_MACROS_SVH
`define LIFE_GENERATION_STENCIL_MACROS_SVH

// concurrent check, off while reset is low
`define LGS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// concurrent check that also runs through reset
`define LGS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* hw/rtl/lgs_pkg.sv */
// types and constants of the life generation stencil
package lgs_pkg;

    localparam int CFG_W = 11;

    localparam logic CFG_ROW_WIDTH    = 1'b0;
    localparam logic CFG_FRAME_HEIGHT = 1'b1;

    localparam logic REQ_CELL  = 1'b0;
    localparam logic REQ_FLUSH = 1'b1;

    localparam logic [3:0] BIRTH_COUNT   = 4'd3;
    localparam logic [3:0] SURVIVE_COUNT = 4'd2;

    // which neighbours of the centre cell lie on the board
    typedef struct packed {
        logic top_ok;
        logic bot_ok;
        logic left_ok;
        logic right_ok;
    } t_edge_mask;

endpackage

/* hw/rtl/life_generation_stencil.sv */
// pipeline: a result passes the stage 1 register, then the output register, after the word
// that completes its window, which arrives row_width+1 words after the cell itself
// throughput: one word per cycle unless the output stalls; one store read and one write per cell
// reset: counters and valid flags clear, row_width and frame_height return to 1024,
// the line store is not cleared (rows before the board are masked by the counters)
module life_generation_stencil
    import lgs_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // configuration write port
    input  logic             i_cfg_we,
    input  logic             i_cfg_addr,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    // input words
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [7:0]       s_axis_tdata,   // [0] cell_in, [7:1] zero
    input  logic             s_axis_tuser,   // [0] req_type
    // result words
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [0] cell_next, [7:1] zero
    output logic             m_axis_tlast,   // end_of_row
    output logic             m_axis_tuser    // [0] end_of_frame
);

    // column index, column count, output row, row count, input row (saturates at MAX_HEIGHT+1)
    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int CW  = $clog2(MAX_WIDTH + 1);
    localparam int OHW = $clog2(MAX_HEIGHT);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int RW  = $clog2(MAX_HEIGHT + 2);
    localparam int WW  = (CW > CFG_W) ? CW : CFG_W;
    localparam int HH  = (HW > CFG_W) ? HW : CFG_W;

    // configuration registers
    logic [CFG_W-1:0] r_row_width;
    logic [CFG_W-1:0] r_frame_height;

    // position counters, all kept at the input side
    logic [AW-1:0]  r_in_col,  n_in_col;
    logic [RW-1:0]  r_in_row,  n_in_row;
    logic [AW-1:0]  r_out_col, n_out_col;
    logic [OHW-1:0] r_out_row, n_out_row;

    // stage 1: word with its store read data
    logic          r_s1_valid;
    logic          r_s1_v;
    logic [AW-1:0] r_s1_col;
    logic          r_s1_produce;
    logic          r_s1_eor;
    logic          r_s1_eof;
    t_edge_mask    r_s1_mask;
    logic [1:0]    r_rdata;
    logic          r_fwd;
    logic [1:0]    r_fwd_data;

    // line store: bit 0 previous row, bit 1 the row before
    logic [1:0] r_line_mem [MAX_WIDTH];

    // sliding 3x3 window
    logic [8:0] r_window, n_window;

    // output register
    logic r_out_valid;
    logic r_out_cell;
    logic r_out_eor;
    logic r_out_eof;

    logic [WW-1:0] w_cfg, w_eff_wide;
    logic [HH-1:0] h_cfg, h_eff_wide;
    logic [CW-1:0] eff_w;
    logic [HW-1:0] eff_h;

    logic          s_acc;
    logic          s1_adv;
    logic          v_in;
    logic          fwd;
    logic          started;
    logic          produce;
    logic          col_wrap;
    logic          eor;
    logic          eof;
    logic [CW-1:0] in_col_p1;
    logic [CW-1:0] out_col_p1;
    logic [HW-1:0] out_row_p1;
    t_edge_mask    mask;
    logic [1:0]    old;
    logic [2:0]    column;
    logic [1:0]    wdata;
    logic          alive;

    // out of range sizes: zero counts as one, above the maximum counts as the maximum
    assign w_cfg      = WW'(r_row_width);
    assign w_eff_wide = (w_cfg == '0) ? WW'(1) :
                        (w_cfg > WW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : w_cfg;
    assign eff_w      = w_eff_wide[CW-1:0];
    assign h_cfg      = HH'(r_frame_height);
    assign h_eff_wide = (h_cfg == '0) ? HH'(1) :
                        (h_cfg > HH'(MAX_HEIGHT)) ? HH'(MAX_HEIGHT) : h_cfg;
    assign eff_h      = h_eff_wide[HW-1:0];

    // handshakes: stage 1 moves on when the output register is free or being emptied
    assign s1_adv        = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || s1_adv;
    assign s_acc         = s_axis_tvalid && s_axis_tready;

    // flush words enter as dead cells
    assign v_in = (s_axis_tuser == REQ_CELL) ? s_axis_tdata[0] : 1'b0;

    // same column written by stage 1 at the edge it is read (one-cell rows)
    assign fwd = s1_adv && (r_s1_col == r_in_col);

    // frame control for the accepted word
    always_comb begin
        in_col_p1  = CW'(r_in_col) + CW'(1);
        out_col_p1 = CW'(r_out_col) + CW'(1);
        out_row_p1 = HW'(r_out_row) + HW'(1);
        col_wrap   = in_col_p1 >= eff_w;
        started    = (r_in_row >= RW'(2)) || ((r_in_row == RW'(1)) && (r_in_col != '0));
        produce    = started && (HW'(r_out_row) < eff_h);
        eor        = out_col_p1 >= eff_w;
        eof        = eor && (out_row_p1 >= eff_h);

        mask.top_ok   = r_out_row != '0;
        mask.bot_ok   = out_row_p1 < eff_h;
        mask.left_ok  = r_out_col != '0;
        mask.right_ok = out_col_p1 < eff_w;

        n_in_col  = col_wrap ? '0 : in_col_p1[AW-1:0];
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (col_wrap && (r_in_row < RW'(MAX_HEIGHT + 1))) begin
            n_in_row = r_in_row + RW'(1);
        end
        if (produce) begin
            if (eof) begin
                // last cell of the board: next word starts a fresh frame
                n_in_col  = '0;
                n_in_row  = '0;
                n_out_col = '0;
                n_out_row = '0;
            end else if (eor) begin
                n_out_col = '0;
                n_out_row = out_row_p1[OHW-1:0];
            end else begin
                n_out_col = out_col_p1[AW-1:0];
            end
        end
    end

    // stage 1: rebuild the column (rows r-2, r-1, r) and shift it into the window
    always_comb begin
        old      = r_fwd ? r_fwd_data : r_rdata;
        column   = {r_s1_v, old[0], old[1]};
        wdata    = {old[0], r_s1_v};
        n_window = {column, r_window[8:3]};
    end

    lgs_rule u_rule (
        .i_window (n_window),
        .i_mask   (r_s1_mask),
        .o_alive  (alive)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width    <= CFG_W'(1024);
            r_frame_height <= CFG_W'(1024);
            r_in_col       <= '0;
            r_in_row       <= '0;
            r_out_col      <= '0;
            r_out_row      <= '0;
            r_s1_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_window       <= '0;
        end else begin
            if (i_cfg_we) begin
                // a register write restarts the frame
                case (i_cfg_addr)
                    CFG_ROW_WIDTH:    r_row_width    <= i_cfg_wdata;
                    CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_wdata;
                    default:          r_row_width    <= r_row_width;
                endcase
                r_in_col  <= '0;
                r_in_row  <= '0;
                r_out_col <= '0;
                r_out_row <= '0;
            end else if (s_acc) begin
                r_in_col  <= n_in_col;
                r_in_row  <= n_in_row;
                r_out_col <= n_out_col;
                r_out_row <= n_out_row;
            end

            if (s_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end

            if (s1_adv) begin
                r_window    <= n_window;
                r_out_valid <= r_s1_produce;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // stage 1 payload and store read
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_s1_v       <= v_in;
            r_s1_col     <= r_in_col;
            r_s1_produce <= produce;
            r_s1_eor     <= eor;
            r_s1_eof     <= eof;
            r_s1_mask    <= mask;
            r_rdata      <= r_line_mem[r_in_col];
            r_fwd        <= fwd;
            r_fwd_data   <= wdata;
        end
    end

    // store write
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_line_mem[r_s1_col] <= wdata;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_cell <= alive;
            r_out_eor  <= r_s1_eor;
            r_out_eof  <= r_s1_eof;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'b0, r_out_cell};
    assign m_axis_tlast  = r_out_eor;
    assign m_axis_tuser  = r_out_eof;

endmodule

/* hw/rtl/lgs_rule.sv */
// b3/s23 rule on a 3x3 window with board edge masking
module lgs_rule
    import lgs_pkg::*;
(
    input  logic [8:0]  i_window,
    input  t_edge_mask  i_mask,
    output logic        o_alive
);

    logic [7:0] nb;
    logic [3:0] cnt;

    // window: three columns left..right, bit 0 of a column is the upper row
    assign nb = {i_window[8] & i_mask.bot_ok & i_mask.right_ok,
                 i_window[7] & i_mask.right_ok,
                 i_window[6] & i_mask.top_ok & i_mask.right_ok,
                 i_window[5] & i_mask.bot_ok,
                 i_window[3] & i_mask.top_ok,
                 i_window[2] & i_mask.bot_ok & i_mask.left_ok,
                 i_window[1] & i_mask.left_ok,
                 i_window[0] & i_mask.top_ok & i_mask.left_ok};

    always_comb begin
        cnt = 4'd0;
        for (int i = 0; i < 8; i++) begin
            cnt = cnt + 4'(nb[i]);
        end
    end

    assign o_alive = (cnt == BIRTH_COUNT) || ((cnt == SURVIVE_COUNT) && i_window[4]);

endmodule

/* hw/rtl/lgs_checker.sv */
// port-level checks for the life generation stencil, bound to the top level
`include "life_generation_stencil_macros.svh"

module lgs_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast,
    input logic       m_axis_tuser
);

    // a stalled result word holds
    `LGS_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser), "result word changed while stalled")

    // the last cell of the board is also the last of its row
    `LGS_ASSERT(a_eof_eor, m_axis_tvalid && m_axis_tuser |-> m_axis_tlast, "end of frame without end of row")

    // padding bits of the result stay zero
    `LGS_ASSERT(a_pad_zero, m_axis_tvalid |-> (m_axis_tdata[7:1] == 7'b0), "result padding not zero")

    // reset empties the pipeline and opens the input
    `LGS_ASSERT_ALWAYS(a_reset_clear, !i_rst_n |=> !m_axis_tvalid && s_axis_tready, "pipeline not clear after reset")

endmodule

bind life_generation_stencil lgs_checker u_lgs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);
